@@ src/sre_pkg.sv @@
package sre_pkg;

	localparam int NUM_REGISTERS_DEF = 16;
	localparam int STACK_DEPTH_DEF = 256;
	localparam int ADDRESS_BITS_DEF = 16;
	localparam int DATA_W = 32;

	localparam logic [4:0] OP_HALT = 5'd0;
	localparam logic [4:0] OP_PUSH = 5'd1;
	localparam logic [4:0] OP_POP = 5'd2;
	localparam logic [4:0] OP_SET = 5'd3;
	localparam logic [4:0] OP_ADD = 5'd4;
	localparam logic [4:0] OP_MUL = 5'd5;
	localparam logic [4:0] OP_SUB = 5'd6;
	localparam logic [4:0] OP_DIV = 5'd7;
	localparam logic [4:0] OP_MOD = 5'd8;
	localparam logic [4:0] OP_RPUSH = 5'd9;
	localparam logic [4:0] OP_RPOP = 5'd10;
	localparam logic [4:0] OP_AND = 5'd11;
	localparam logic [4:0] OP_OR = 5'd12;
	localparam logic [4:0] OP_NOT = 5'd13;
	localparam logic [4:0] OP_XOR = 5'd14;
	localparam logic [4:0] OP_BEQ = 5'd15;
	localparam logic [4:0] OP_BNE = 5'd16;
	localparam logic [4:0] OP_BLT = 5'd17;
	localparam logic [4:0] OP_BGT = 5'd18;
	localparam logic [4:0] OP_BGE = 5'd19;
	localparam logic [4:0] OP_BLE = 5'd20;
	localparam logic [4:0] OP_BEQZ = 5'd21;
	localparam logic [4:0] OP_BGEZ = 5'd22;
	localparam logic [4:0] OP_BNEZ = 5'd23;
	localparam logic [4:0] OP_BLEZ = 5'd24;
	localparam logic [4:0] OP_BLTZ = 5'd25;
	localparam logic [4:0] OP_BGTZ = 5'd26;
	localparam logic [4:0] OP_JUMP = 5'd27;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_HALT = 3'd1;
	localparam logic [2:0] ST_BAD = 3'd2;
	localparam logic [2:0] ST_DIVZ = 3'd3;
	localparam logic [2:0] ST_OVER = 3'd4;
	localparam logic [2:0] ST_UNDER = 3'd5;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture input beat
		logic exec;      // decode-state ops and final writes
		logic div_start;
		logic div_step;
		logic div_fin;   // commit divide result
		logic rd_start;  // start register/stack read
		logic rd_fin;    // commit read result
	} sre_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_div;
		logic is_read;
		logic div_last;
	} sre_sts_t;

endpackage

@@ src/sre_datapath.sv @@
module sre_datapath #(
	parameter int NUM_REGISTERS = sre_pkg::NUM_REGISTERS_DEF,
	parameter int STACK_DEPTH = sre_pkg::STACK_DEPTH_DEF,
	parameter int ADDRESS_BITS = sre_pkg::ADDRESS_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  sre_pkg::sre_cmd_t cmd,
	output sre_pkg::sre_sts_t sts,
	input  logic [4:0] mode,
	input  logic [3:0] dest_reg,
	input  logic [31:0] operand_a,
	input  logic [31:0] operand_b,
	input  logic [15:0] jump_target,
	output logic [2:0] status,
	output logic branch_taken,
	output logic [15:0] branch_address,
	output logic popped_valid,
	output logic [31:0] popped_value
);
	localparam int RW = (NUM_REGISTERS > 1) ? $clog2(NUM_REGISTERS) : 1;
	localparam int SW = $clog2(STACK_DEPTH);
	localparam int CW = SW + 1;
	localparam int AB = (ADDRESS_BITS < 16) ? ADDRESS_BITS : 16;
	localparam logic [15:0] AMASK = 16'((17'd1 << AB) - 17'd1);
	localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

	logic [4:0] op_q;
	logic [3:0] r_q;
	logic [31:0] a_q, b_q;
	logic [15:0] tgt_q;

	logic [31:0] rf_q [NUM_REGISTERS];
	logic [31:0] stk_mem [STACK_DEPTH];
	logic [CW-1:0] cnt_q;
	logic [31:0] rd_q;

	logic [31:0] rem_q, quo_q, dvs_q;
	logic [5:0] dcnt_q;
	logic neg_q_q, neg_r_q;

	logic reg_ok, full, empty;
	logic [RW-1:0] ridx;
	logic [SW-1:0] top_idx, push_idx;
	logic sa_n, sb_n;
	logic [32:0] trial;

	assign ridx = RW'(r_q);
	assign reg_ok = ({28'd0, r_q} < 32'(NUM_REGISTERS));
	assign full = (cnt_q >= DEPTH_C);
	assign empty = (cnt_q == '0);
	assign top_idx = SW'(cnt_q - CW'(1));
	assign push_idx = cnt_q[SW-1:0];
	assign sa_n = a_q[31];
	assign sb_n = b_q[31];
	assign trial = {rem_q, quo_q[31]} - {1'b0, dvs_q};

	assign sts.is_div = (op_q == sre_pkg::OP_DIV || op_q == sre_pkg::OP_MOD)
		&& reg_ok && (b_q != '0);
	assign sts.is_read = (op_q == sre_pkg::OP_POP && !empty)
		|| (op_q == sre_pkg::OP_RPUSH && reg_ok && !full)
		|| (op_q == sre_pkg::OP_RPOP && reg_ok && !empty);
	assign sts.div_last = (dcnt_q == 6'd31);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= mode;
			r_q <= dest_reg;
			a_q <= operand_a;
			b_q <= operand_b;
			tgt_q <= jump_target;
		end
	end

	// stack memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.rd_start) begin
			rd_q <= (op_q == sre_pkg::OP_RPUSH) ? rf_q[ridx] : stk_mem[top_idx];
		end
		if (cmd.exec && op_q == sre_pkg::OP_PUSH && !full) begin
			stk_mem[push_idx] <= a_q;
		end else if (cmd.rd_fin && op_q == sre_pkg::OP_RPUSH) begin
			stk_mem[push_idx] <= rd_q;
		end
	end

	// restoring divider, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= '0;
			quo_q <= sa_n ? 32'(-a_q) : a_q;
			dvs_q <= sb_n ? 32'(-b_q) : b_q;
			dcnt_q <= '0;
			neg_q_q <= sa_n ^ sb_n;
			neg_r_q <= sa_n;
		end else if (cmd.div_step) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
			dcnt_q <= dcnt_q + 6'd1;
		end
	end

	logic [31:0] alu_v;
	logic alu_wr;
	logic cond;
	logic [2:0] st;
	logic [63:0] prod;

	assign prod = a_q * b_q;

	always_comb begin
		alu_v = '0;
		alu_wr = 1'b0;
		cond = 1'b0;
		st = sre_pkg::ST_OK;
		unique case (op_q)
			sre_pkg::OP_HALT: st = sre_pkg::ST_HALT;
			sre_pkg::OP_PUSH: if (full) st = sre_pkg::ST_OVER;
			sre_pkg::OP_POP: if (empty) st = sre_pkg::ST_UNDER;
			sre_pkg::OP_SET, sre_pkg::OP_ADD, sre_pkg::OP_MUL, sre_pkg::OP_SUB,
			sre_pkg::OP_AND, sre_pkg::OP_OR, sre_pkg::OP_NOT, sre_pkg::OP_XOR: begin
				if (!reg_ok) st = sre_pkg::ST_BAD;
				else alu_wr = 1'b1;
				unique case (op_q)
					sre_pkg::OP_SET: alu_v = a_q;
					sre_pkg::OP_ADD: alu_v = a_q + b_q;
					sre_pkg::OP_MUL: alu_v = prod[31:0];
					sre_pkg::OP_SUB: alu_v = a_q - b_q;
					sre_pkg::OP_AND: alu_v = a_q & b_q;
					sre_pkg::OP_OR: alu_v = a_q | b_q;
					sre_pkg::OP_NOT: alu_v = ~a_q;
					default: alu_v = a_q ^ b_q;
				endcase
			end
			sre_pkg::OP_DIV, sre_pkg::OP_MOD: begin
				if (!reg_ok) st = sre_pkg::ST_BAD;
				else if (b_q == '0) st = sre_pkg::ST_DIVZ;
			end
			sre_pkg::OP_RPUSH: begin
				if (!reg_ok) st = sre_pkg::ST_BAD;
				else if (full) st = sre_pkg::ST_OVER;
			end
			sre_pkg::OP_RPOP: begin
				if (!reg_ok) st = sre_pkg::ST_BAD;
				else if (empty) st = sre_pkg::ST_UNDER;
			end
			sre_pkg::OP_BEQ: cond = (a_q == b_q);
			sre_pkg::OP_BNE: cond = (a_q != b_q);
			sre_pkg::OP_BLT: cond = ($signed(a_q) < $signed(b_q));
			sre_pkg::OP_BGT: cond = ($signed(a_q) > $signed(b_q));
			sre_pkg::OP_BGE: cond = ($signed(a_q) >= $signed(b_q));
			sre_pkg::OP_BLE: cond = ($signed(a_q) <= $signed(b_q));
			sre_pkg::OP_BEQZ: cond = (a_q == '0);
			sre_pkg::OP_BGEZ: cond = !sa_n;
			sre_pkg::OP_BNEZ: cond = (a_q != '0);
			sre_pkg::OP_BLEZ: cond = sa_n || (a_q == '0);
			sre_pkg::OP_BLTZ: cond = sa_n;
			sre_pkg::OP_BGTZ: cond = !sa_n && (a_q != '0);
			sre_pkg::OP_JUMP: cond = 1'b1;
			default: st = sre_pkg::ST_BAD;
		endcase
	end

	logic [31:0] dq, dr;
	assign dq = neg_q_q ? 32'(-quo_q) : quo_q;
	assign dr = neg_r_q ? 32'(-rem_q) : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			for (int i = 0; i < NUM_REGISTERS; i++) rf_q[i] <= '0;
		end else begin
			if (cmd.exec) begin
				if (alu_wr) rf_q[ridx] <= alu_v;
				if (op_q == sre_pkg::OP_PUSH && !full) cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.div_fin) rf_q[ridx] <= (op_q == sre_pkg::OP_DIV) ? dq : dr;
			if (cmd.rd_fin) begin
				if (op_q == sre_pkg::OP_RPOP) rf_q[ridx] <= rd_q;
				if (op_q == sre_pkg::OP_RPUSH) cnt_q <= cnt_q + CW'(1);
				else cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.exec || cmd.div_fin || cmd.rd_fin) begin
			status <= st;
			branch_taken <= cond;
			branch_address <= cond ? (tgt_q & AMASK) : '0;
			popped_valid <= cmd.rd_fin && op_q == sre_pkg::OP_POP;
			popped_value <= (cmd.rd_fin && op_q == sre_pkg::OP_POP) ? rd_q : '0;
		end
	end
endmodule

@@ src/sre_ctrl.sv @@
module sre_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	output logic m_tvalid,
	input  logic m_tready,
	input  sre_pkg::sre_sts_t sts,
	output sre_pkg::sre_cmd_t cmd
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC = 3'd1;
	localparam logic [2:0] S_DIV = 3'd2;
	localparam logic [2:0] S_DFIN = 3'd3;
	localparam logic [2:0] S_RD = 3'd4;
	localparam logic [2:0] S_OUT = 3'd5;

	logic [2:0] state_q, nxt;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_OUT);

	always_comb begin
		cmd = '0;
		nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = s_tvalid;
				if (s_tvalid) nxt = S_DEC;
			end
			S_DEC: begin
				if (sts.is_div) begin
					cmd.div_start = 1'b1;
					nxt = S_DIV;
				end else if (sts.is_read) begin
					cmd.rd_start = 1'b1;
					nxt = S_RD;
				end else begin
					cmd.exec = 1'b1;
					nxt = S_OUT;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) nxt = S_DFIN;
			end
			S_DFIN: begin
				cmd.div_fin = 1'b1;
				nxt = S_OUT;
			end
			S_RD: begin
				cmd.rd_fin = 1'b1;
				nxt = S_OUT;
			end
			S_OUT: if (m_tready) nxt = S_IDLE;
			default: nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= nxt;
	end
endmodule

@@ src/stack_register_instruction_executor.sv @@
// flow: an accepted beat is captured, decoded and its result registered for output;
// pop, regpush and regpop add a read state, divide and modulo add the divide steps
// and a commit state; no new beat is taken until the result has been accepted,
// and the radix-2 divider takes one quotient bit per cycle
// reset: arst_n clears the register file, stack count and controller at once;
// stack contents stay undefined until pushed
module stack_register_instruction_executor #(
	parameter int NUM_REGISTERS = sre_pkg::NUM_REGISTERS_DEF,
	parameter int STACK_DEPTH = sre_pkg::STACK_DEPTH_DEF,
	parameter int ADDRESS_BITS = sre_pkg::ADDRESS_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [95:0] s_tdata, // mode, dest_reg, operand_a, operand_b, jump_target
	output logic m_tvalid,
	input  logic m_tready,
	output logic [55:0] m_tdata  // status, branch_taken, branch_address,
	                             // popped_valid, popped_value
);
	sre_pkg::sre_cmd_t cmd;
	sre_pkg::sre_sts_t sts;
	logic [2:0] status;
	logic branch_taken, popped_valid;
	logic [15:0] branch_address;
	logic [31:0] popped_value;

	sre_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .sts(sts), .cmd(cmd)
	);

	sre_datapath #(
		.NUM_REGISTERS(NUM_REGISTERS), .STACK_DEPTH(STACK_DEPTH),
		.ADDRESS_BITS(ADDRESS_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.mode(s_tdata[4:0]), .dest_reg(s_tdata[8:5]), .operand_a(s_tdata[40:9]),
		.operand_b(s_tdata[72:41]), .jump_target(s_tdata[88:73]),
		.status(status), .branch_taken(branch_taken), .branch_address(branch_address),
		.popped_valid(popped_valid), .popped_value(popped_value)
	);

	assign m_tdata = {3'd0, popped_value, popped_valid, branch_address,
		branch_taken, status};
endmodule

@@ src/sre_checker.sv @@
module sre_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [55:0] m_tdata
);
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid)) else $error("input open while result pending");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input still open after accepted beat");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");
	a_nottaken: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[3] |-> m_tdata[19:4] == 16'd0)
		else $error("address without branch");
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[20] |-> m_tdata[2:0] == 3'd0 && !m_tdata[3])
		else $error("pop flag with bad status");
endmodule

bind stack_register_instruction_executor sre_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

@@ tb/sv/stack_register_instruction_executor_tb.sv @@
module stack_register_instruction_executor_tb;

	typedef struct packed {
		logic [2:0] status;
		logic taken;
		logic [15:0] address;
		logic pvalid;
		logic [31:0] pvalue;
	} outcome_t;

	typedef struct {
		logic [4:0] op;
		logic [3:0] r;
		logic [31:0] a;
		logic [31:0] b;
		logic [15:0] tgt;
		bit known;
		logic [2:0] st;
	} instr_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [95:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [55:0] m_tdata;

	logic [31:0] regs_model [16];
	logic [31:0] stack_model [256];
	int depth_model;
	outcome_t outcome_q [$];
	int errors = 0;
	int cycle = 0;
	int send_idle = 0;
	int recv_stall = 0;
	instr_row_t rows [$];

	stack_register_instruction_executor dut (.*);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > 400000) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic outcome_t execute(input instr_row_t it);
		outcome_t o;
		logic cond;
		logic [31:0] v, ma, mb, q, m;
		logic sa, sb;
		o = '0;
		cond = 0;
		v = 0;
		sa = it.a[31];
		sb = it.b[31];
		case (it.op)
			sre_pkg::OP_HALT: o.status = sre_pkg::ST_HALT;
			sre_pkg::OP_PUSH:
				if (depth_model >= 256) o.status = sre_pkg::ST_OVER;
				else begin
					stack_model[depth_model] = it.a;
					depth_model++;
				end
			sre_pkg::OP_POP:
				if (depth_model == 0) o.status = sre_pkg::ST_UNDER;
				else begin
					depth_model--;
					o.pvalid = 1;
					o.pvalue = stack_model[depth_model];
				end
			sre_pkg::OP_SET, sre_pkg::OP_ADD, sre_pkg::OP_MUL, sre_pkg::OP_SUB,
			sre_pkg::OP_DIV, sre_pkg::OP_MOD, sre_pkg::OP_AND, sre_pkg::OP_OR,
			sre_pkg::OP_NOT, sre_pkg::OP_XOR: begin
				if ((it.op == sre_pkg::OP_DIV || it.op == sre_pkg::OP_MOD) && it.b == 0)
					o.status = sre_pkg::ST_DIVZ;
				else begin
					case (it.op)
						sre_pkg::OP_SET: v = it.a;
						sre_pkg::OP_ADD: v = it.a + it.b;
						sre_pkg::OP_MUL: v = it.a * it.b;
						sre_pkg::OP_SUB: v = it.a - it.b;
						sre_pkg::OP_AND: v = it.a & it.b;
						sre_pkg::OP_OR: v = it.a | it.b;
						sre_pkg::OP_NOT: v = ~it.a;
						sre_pkg::OP_XOR: v = it.a ^ it.b;
						default: begin
							ma = sa ? -it.a : it.a;
							mb = sb ? -it.b : it.b;
							q = ma / mb;
							m = ma % mb;
							if (sa != sb) q = -q;
							if (sa) m = -m;
							v = (it.op == sre_pkg::OP_DIV) ? q : m;
						end
					endcase
					regs_model[it.r] = v;
				end
			end
			sre_pkg::OP_RPUSH:
				if (depth_model >= 256) o.status = sre_pkg::ST_OVER;
				else begin
					stack_model[depth_model] = regs_model[it.r];
					depth_model++;
				end
			sre_pkg::OP_RPOP:
				if (depth_model == 0) o.status = sre_pkg::ST_UNDER;
				else begin
					depth_model--;
					regs_model[it.r] = stack_model[depth_model];
				end
			sre_pkg::OP_BEQ: cond = $signed(it.a) == $signed(it.b);
			sre_pkg::OP_BNE: cond = $signed(it.a) != $signed(it.b);
			sre_pkg::OP_BLT: cond = $signed(it.a) < $signed(it.b);
			sre_pkg::OP_BGT: cond = $signed(it.a) > $signed(it.b);
			sre_pkg::OP_BGE: cond = $signed(it.a) >= $signed(it.b);
			sre_pkg::OP_BLE: cond = $signed(it.a) <= $signed(it.b);
			sre_pkg::OP_BEQZ: cond = $signed(it.a) == 0;
			sre_pkg::OP_BGEZ: cond = $signed(it.a) >= 0;
			sre_pkg::OP_BNEZ: cond = $signed(it.a) != 0;
			sre_pkg::OP_BLEZ: cond = $signed(it.a) <= 0;
			sre_pkg::OP_BLTZ: cond = $signed(it.a) < 0;
			sre_pkg::OP_BGTZ: cond = $signed(it.a) > 0;
			sre_pkg::OP_JUMP: cond = 1;
			default: o.status = sre_pkg::ST_BAD;
		endcase
		o.taken = cond;
		o.address = cond ? it.tgt : 16'd0;
		return o;
	endfunction

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return 32'($signed($urandom_range(0, 6)) - 3);
			default: return $urandom;
		endcase
	endfunction

	task automatic send(input instr_row_t it);
		outcome_t o;
		while (send_idle > 0 && $urandom_range(0, 99) < send_idle) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tdata <= {7'd0, it.tgt, it.b, it.a, it.r, it.op};
		s_tvalid <= 1;
		do @(posedge clk); while (!s_tready);
		o = execute(it);
		if (it.known && o.status != it.st) begin
			$display("%0t row status expected %0d actual %0d", $time, it.st, o.status);
			errors++;
		end
		outcome_q.push_back(o);
	endtask

	always @(posedge clk) begin
		outcome_t got, want;
		if (m_tvalid && m_tready) begin
			got = {m_tdata[2:0], m_tdata[3], m_tdata[19:4], m_tdata[20], m_tdata[52:21]};
			if (outcome_q.size() == 0) begin
				$display("%0t unexpected beat %h", $time, m_tdata);
				errors++;
			end else begin
				want = outcome_q.pop_front();
				if (got !== want) begin
					$display("%0t expected %h actual %h", $time, want, got);
					errors++;
				end
			end
		end
		m_tready <= (recv_stall == 0) || ($urandom_range(0, 99) >= recv_stall);
	end

	function automatic instr_row_t mk(input logic [4:0] op, input logic [3:0] r,
			input logic [31:0] a, input logic [31:0] b, input logic [15:0] tgt,
			input bit known = 0, input logic [2:0] st = sre_pkg::ST_OK);
		instr_row_t it;
		it.op = op; it.r = r; it.a = a; it.b = b; it.tgt = tgt;
		it.known = known; it.st = st;
		return it;
	endfunction

	function automatic instr_row_t rand_instr();
		instr_row_t it;
		int k;
		it = mk(5'($urandom_range(0, 31)), 4'($urandom), rand_operand(), rand_operand(),
			16'($urandom));
		k = $urandom_range(0, 99);
		if (k < 20) it.op = depth_model < 200 ? sre_pkg::OP_PUSH : sre_pkg::OP_POP;
		else if (k < 30) it.op = sre_pkg::OP_RPUSH;
		else if (k < 40) it.op = depth_model > 0 ? sre_pkg::OP_POP : sre_pkg::OP_PUSH;
		else if (k < 47) it.op = sre_pkg::OP_RPOP;
		else if (k < 52) it.op = $urandom_range(0, 1) ? sre_pkg::OP_DIV : sre_pkg::OP_MOD;
		else if (k < 90) it.op = 5'($urandom_range(sre_pkg::OP_SET, sre_pkg::OP_JUMP));
		if ((it.op == sre_pkg::OP_DIV || it.op == sre_pkg::OP_MOD)
				&& $urandom_range(0, 9) == 0) it.b = 0;
		return it;
	endfunction

	initial begin
		instr_row_t it;
		rows.push_back(mk(sre_pkg::OP_POP, 0, 0, 0, 0, 1, sre_pkg::ST_UNDER));
		rows.push_back(mk(sre_pkg::OP_RPOP, 1, 0, 0, 0, 1, sre_pkg::ST_UNDER));
		rows.push_back(mk(sre_pkg::OP_HALT, 0, 0, 0, 0, 1, sre_pkg::ST_HALT));
		rows.push_back(mk(5'd28, 15, 0, 0, 0, 1, sre_pkg::ST_BAD));
		rows.push_back(mk(5'd31, 0, 0, 0, 0, 1, sre_pkg::ST_BAD));
		rows.push_back(mk(sre_pkg::OP_DIV, 2, 5, 0, 0, 1, sre_pkg::ST_DIVZ));
		rows.push_back(mk(sre_pkg::OP_MOD, 2, 5, 0, 0, 1, sre_pkg::ST_DIVZ));
		rows.push_back(mk(sre_pkg::OP_DIV, 3, 32'h8000_0000, 32'hffff_ffff, 0));
		rows.push_back(mk(sre_pkg::OP_MOD, 4, 32'h8000_0000, 32'hffff_ffff, 0));
		rows.push_back(mk(sre_pkg::OP_DIV, 5, -7, 2, 0));
		rows.push_back(mk(sre_pkg::OP_MOD, 6, -7, 2, 0));
		rows.push_back(mk(sre_pkg::OP_ADD, 7, 32'h7fff_ffff, 1, 0));
		rows.push_back(mk(sre_pkg::OP_MUL, 8, 32'h7fff_ffff, 32'h7fff_ffff, 0));
		rows.push_back(mk(sre_pkg::OP_SUB, 9, 32'h8000_0000, 1, 0));
		rows.push_back(mk(sre_pkg::OP_AND, 10, 32'hf0f0_f0f0, 32'hffff_0000, 0));
		rows.push_back(mk(sre_pkg::OP_OR, 11, 32'h0f0f_0f0f, 32'hffff_0000, 0));
		rows.push_back(mk(sre_pkg::OP_NOT, 12, 0, 0, 0));
		rows.push_back(mk(sre_pkg::OP_XOR, 13, 32'haaaa_aaaa, 32'hffff_ffff, 0));
		rows.push_back(mk(sre_pkg::OP_SET, 15, 32'hdead_beef, 0, 0));
		rows.push_back(mk(sre_pkg::OP_RPUSH, 15, 0, 0, 0));
		rows.push_back(mk(sre_pkg::OP_PUSH, 0, 32'h8000_0000, 0, 0));
		rows.push_back(mk(sre_pkg::OP_POP, 0, 0, 0, 0));
		rows.push_back(mk(sre_pkg::OP_RPOP, 14, 0, 0, 0));
		rows.push_back(mk(sre_pkg::OP_BLT, 0, 32'h8000_0000, 32'h7fff_ffff, 16'hffff));
		rows.push_back(mk(sre_pkg::OP_JUMP, 0, 0, 0, 16'h0000));
		for (int i = 0; i < 16; i++) regs_model[i] = 0;
		depth_model = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (rows[i]) send(rows[i]);
		// fill past overflow and drain past underflow
		for (int i = 0; i < 258; i++)
			send(mk(sre_pkg::OP_PUSH, 0, $urandom, 0, 0, i >= 256, sre_pkg::ST_OVER));
		send(mk(sre_pkg::OP_RPUSH, 3, 0, 0, 0, 1, sre_pkg::ST_OVER));
		for (int i = 0; i < 257; i++)
			send(mk(sre_pkg::OP_POP, 0, 0, 0, 0, i >= 256, sre_pkg::ST_UNDER));
		for (int ph = 0; ph < 4; ph++) begin
			send_idle = (ph == 1 || ph == 3) ? (ph == 3 ? 16 : 66) : 0;
			recv_stall = (ph == 2 || ph == 3) ? (ph == 3 ? 16 : 66) : 0;
			for (int i = 0; i < 350; i++) begin
				it = rand_instr();
				send(it);
			end
		end
		s_tvalid <= 0;
		while (outcome_q.size() > 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule

@@ filelist.f @@
src/sre_pkg.sv
src/sre_datapath.sv
src/sre_ctrl.sv
src/stack_register_instruction_executor.sv
src/sre_checker.sv
tb/sv/stack_register_instruction_executor_tb.sv
